// ===== rtl/gripper_grasp_fsm_macros.svh =====
// assertion macros used by the checker file
`ifndef GRIPPER_GRASP_FSM_MACROS_SVH
`define GRIPPER_GRASP_FSM_MACROS_SVH

// condition implies consequence in the same cycle
`define GGF_ASSERT_NOW(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("%m: check failed");

// condition implies consequence in the next cycle
`define GGF_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/ggf_pkg.sv =====
package ggf_pkg;

    // field widths
    localparam int AngleW   = 11;
    localparam int TimeW    = 32;
    localparam int TimeoutW = 16;
    localparam int KindW    = 2;
    localparam int StateW   = 3;

    // stream packing
    localparam int InDataW  = 48;
    localparam int OutDataW = 24;

    // configuration port
    localparam int AddrW = 5;
    localparam int DataW = 32;

    localparam logic [AngleW-1:0]   AngleMax      = 11'd1800;
    localparam logic [AngleW-1:0]   OpenAngleRst  = 11'd900;
    localparam logic [AngleW-1:0]   CloseAngleRst = 11'd100;
    localparam logic [AngleW-1:0]   CloseStepRst  = 11'd20;
    localparam logic [AngleW-1:0]   StallRst      = 11'd50;
    localparam logic [TimeoutW-1:0] TimeoutRst    = 16'd1500;

    typedef enum logic [StateW-1:0] {
        ST_OPEN    = 3'd0,
        ST_CLOSING = 3'd1,
        ST_CLOSED  = 3'd2,
        ST_GRASPED = 3'd3,
        ST_OPENING = 3'd4
    } ggf_state_t;

    typedef enum logic [KindW-1:0] {
        KIND_TICK  = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_SET   = 2'd3
    } ggf_kind_t;

    typedef enum logic [2:0] {
        REG_OPEN_ANGLE  = 3'd0,
        REG_CLOSE_ANGLE = 3'd1,
        REG_CLOSE_STEP  = 3'd2,
        REG_STALL       = 3'd3,
        REG_TIMEOUT     = 3'd4
    } ggf_reg_t;

endpackage

// ===== rtl/gripper_grasp_fsm.sv =====
// Gripper grasp controller. Each request on the s_ stream is a tick, an open command, a
// close command or a set-angle command with a millisecond timestamp; each yields exactly
// one result on the m_ stream with the new state, the commanded angle and the servo strobes.
// One request is taken every clock cycle unless m_tready stalls; a result passes the input
// register and then the result register, with the state update (one subtract, a clamp and
// a few compares) in between. m_tready low stalls both stages once they are full. The user
// must write configuration over APB only while no request is in flight; it is not enforced.
module gripper_grasp_fsm
    import ggf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready,
    // requests
    input  logic                s_tvalid,
    output logic                s_tready,
    // now_ms [31:0], angle_in [42:32], servo_busy [43], zero [47:44]
    input  logic [InDataW-1:0]  s_tdata,
    // kind [1:0]
    input  logic [KindW-1:0]    s_tuser,
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    // state_code [2:0], angle_out [13:3], angle_write [14], open_move_start [15],
    // grasped_flag [16], zero [23:17]
    output logic [OutDataW-1:0] m_tdata
);

    // configuration registers
    logic [AngleW-1:0]   open_angle_reg;
    logic [AngleW-1:0]   close_angle_reg;
    logic [AngleW-1:0]   close_step_reg;
    logic [AngleW-1:0]   stall_margin_reg;
    logic [TimeoutW-1:0] timeout_reg;

    // input stage
    logic                in_valid_reg;
    ggf_kind_t           in_kind_reg;
    logic [TimeW-1:0]    in_now_reg;
    logic [AngleW-1:0]   in_angle_reg;
    logic                in_busy_reg;

    // controller state
    ggf_state_t          state_reg, state_next;
    logic [AngleW-1:0]   angle_reg, angle_next;
    logic [TimeW-1:0]    start_reg, start_next;

    // result stage
    logic                out_valid_reg;
    ggf_state_t          out_state_reg;
    logic [AngleW-1:0]   out_angle_reg;
    logic                out_write_reg, out_move_reg, out_grasp_reg;

    logic                out_free, advance;
    logic                wr_next, move_next;
    logic [TimeW-1:0]    elapsed;
    logic                timed_out;
    logic [AngleW:0]     stall_level;
    logic [AngleW:0]     step_diff;
    logic [AngleW-1:0]   sat_angle;
    logic [2:0]          reg_index;
    logic                cfg_write;

    // apb access
    assign pready    = 1'b1;
    assign reg_index = paddr[AddrW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_angle_reg   <= OpenAngleRst;
            close_angle_reg  <= CloseAngleRst;
            close_step_reg   <= CloseStepRst;
            stall_margin_reg <= StallRst;
            timeout_reg      <= TimeoutRst;
        end else if (cfg_write) begin
            case (reg_index)
                REG_OPEN_ANGLE:  open_angle_reg   <= pwdata[AngleW-1:0];
                REG_CLOSE_ANGLE: close_angle_reg  <= pwdata[AngleW-1:0];
                REG_CLOSE_STEP:  close_step_reg   <= pwdata[AngleW-1:0];
                REG_STALL:       stall_margin_reg <= pwdata[AngleW-1:0];
                REG_TIMEOUT:     timeout_reg      <= pwdata[TimeoutW-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_index)
            REG_OPEN_ANGLE:  prdata = {{(DataW-AngleW){1'b0}}, open_angle_reg};
            REG_CLOSE_ANGLE: prdata = {{(DataW-AngleW){1'b0}}, close_angle_reg};
            REG_CLOSE_STEP:  prdata = {{(DataW-AngleW){1'b0}}, close_step_reg};
            REG_STALL:       prdata = {{(DataW-AngleW){1'b0}}, stall_margin_reg};
            REG_TIMEOUT:     prdata = {{(DataW-TimeoutW){1'b0}}, timeout_reg};
            default:         prdata = '0;
        endcase
    end

    // pipeline flow
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg  <= ggf_kind_t'(s_tuser);
            in_now_reg   <= s_tdata[TimeW-1:0];
            in_angle_reg <= s_tdata[TimeW+AngleW-1:TimeW];
            in_busy_reg  <= s_tdata[TimeW+AngleW];
        end
    end

    // shared datapath terms
    assign elapsed     = in_now_reg - start_reg;
    assign timed_out   = elapsed > {{(TimeW-TimeoutW){1'b0}}, timeout_reg};
    assign stall_level = {1'b0, close_angle_reg} + {1'b0, stall_margin_reg};
    assign step_diff   = {1'b0, angle_reg} - {1'b0, close_step_reg};
    assign sat_angle   = (in_angle_reg > AngleMax) ? AngleMax : in_angle_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (in_kind_reg)
            KIND_TICK: begin
                case (state_reg)
                    ST_CLOSING: begin
                        if (timed_out) begin
                            state_next = ({1'b0, angle_reg} > stall_level) ? ST_GRASPED
                                                                          : ST_CLOSED;
                        end else if (!(angle_reg > close_angle_reg)) begin
                            state_next = ST_CLOSED;
                        end
                    end
                    ST_OPENING: begin
                        if (!in_busy_reg) begin
                            state_next = ST_OPEN;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_OPEN:  state_next = ST_OPENING;
            KIND_CLOSE: state_next = ST_CLOSING;
            default: ;
        endcase
    end

    // angle, timestamp and strobes
    always_comb begin
        angle_next = angle_reg;
        start_next = start_reg;
        wr_next    = 1'b0;
        move_next  = 1'b0;
        case (in_kind_reg)
            KIND_TICK: begin
                if (state_reg == ST_CLOSING && !timed_out && angle_reg > close_angle_reg) begin
                    wr_next = 1'b1;
                    if (step_diff[AngleW] || step_diff[AngleW-1:0] < close_angle_reg) begin
                        angle_next = close_angle_reg;
                    end else begin
                        angle_next = step_diff[AngleW-1:0];
                    end
                end else if (state_reg == ST_OPENING && !in_busy_reg) begin
                    angle_next = open_angle_reg;
                end
            end
            KIND_OPEN: move_next = 1'b1;
            KIND_CLOSE: begin
                start_next = in_now_reg;
                angle_next = sat_angle;
            end
            default: begin
                angle_next = sat_angle;
                wr_next    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_OPEN;
            angle_reg <= OpenAngleRst;
            start_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            angle_reg <= angle_next;
            start_reg <= start_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg <= state_next;
            out_angle_reg <= angle_next;
            out_write_reg <= wr_next;
            out_move_reg  <= move_next;
            out_grasp_reg <= (state_next == ST_GRASPED);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-StateW-AngleW-3){1'b0}}, out_grasp_reg, out_move_reg,
                       out_write_reg, out_angle_reg, out_state_reg};

endmodule

// ===== rtl/ggf_checker.sv =====
`include "gripper_grasp_fsm_macros.svh"

module ggf_checker
    import ggf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    logic [StateW-1:0] state_code;
    logic              move_flag;
    logic              grasp_flag;

    assign state_code = m_tdata[StateW-1:0];
    assign move_flag  = m_tdata[StateW+AngleW+1];
    assign grasp_flag = m_tdata[StateW+AngleW+2];

    // grasped flag follows the state code
    `GGF_ASSERT_NOW(a_grasp_flag, aclk, aresetn, m_tvalid, grasp_flag == (state_code == ST_GRASPED))

    // state code stays within the five states
    `GGF_ASSERT_NOW(a_state_range, aclk, aresetn, m_tvalid, state_code <= ST_OPENING)

    // an open move only starts together with the opening state
    `GGF_ASSERT_NOW(a_move_opening, aclk, aresetn, m_tvalid && move_flag, state_code == ST_OPENING)

    // a stalled result holds
    `GGF_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind gripper_grasp_fsm ggf_checker u_ggf_checker (.*);
